[hw/rtl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

  // Field widths of the request and result
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Default ring depth
  localparam int unsigned DEF_DEPTH = 16;

  // Request operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 2'd0,
    MODE_INS_BACK  = 2'd1,
    MODE_REM_FRONT = 2'd2,
    MODE_REM_BACK  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Decoded command handed from front to back
  typedef struct packed {
    logic              is_ins;
    logic              at_front;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

endpackage

[hw/rtl/deq_front.sv]
`timescale 1ns / 1ps

// Accepts requests, decodes the operation and buffers decoded commands
// in a two-entry queue toward the back end.
module deq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [deq_pkg::DATA_W-1:0] in_tdata,
  input  logic [deq_pkg::MODE_W-1:0] in_tuser,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output deq_pkg::cmd_t              cmd
);

  deq_pkg::cmd_t q_data_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  deq_pkg::cmd_t dec;

  // Decode the operation code
  always_comb begin
    dec.value = in_tdata;
    unique case (deq_pkg::mode_t'(in_tuser))
      deq_pkg::MODE_INS_FRONT: begin dec.is_ins = 1'b1; dec.at_front = 1'b1; end
      deq_pkg::MODE_INS_BACK:  begin dec.is_ins = 1'b1; dec.at_front = 1'b0; end
      deq_pkg::MODE_REM_FRONT: begin dec.is_ins = 1'b0; dec.at_front = 1'b1; end
      deq_pkg::MODE_REM_BACK:  begin dec.is_ins = 1'b0; dec.at_front = 1'b0; end
      default:                 begin dec.is_ins = 1'b0; dec.at_front = 1'b0; end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid & in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid & cmd_ready;
  assign cmd       = q_data_r[rd_ptr_r];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[hw/rtl/deq_back.sv]
`timescale 1ns / 1ps

// Executes decoded commands against the ring buffer and drives the
// result register.
module deq_back #(
  parameter int unsigned DEPTH = deq_pkg::DEF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  deq_pkg::cmd_t        cmd,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data_r;

  deq_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [deq_pkg::DATA_W-1:0] out_val_r, out_val_nxt;
  deq_pkg::status_t           out_st_r, out_st_nxt;
  logic [deq_pkg::OCC_W-1:0]  out_occ_r, out_occ_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       slot_free;
  logic                       full, empty;
  logic [AW-1:0]              front_dec, front_inc;
  logic [SW-1:0]              sum_tail, sum_last;
  logic [AW-1:0]              pos_tail, pos_last;
  logic [CW+deq_pkg::OCC_W-1:0] occ_ext;

  // Ring position arithmetic
  always_comb begin
    front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
    front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
    sum_tail  = SW'(front_r) + SW'(count_r);
    sum_last  = sum_tail - 1'b1;
    pos_tail  = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
    pos_last  = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
  end

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign slot_free = ~out_valid_r | out_tready;

  // Sequencer: inserts and flagged requests finish at once, removals
  // pass through BK_READ for the registered ring read.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    cmd_ready     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = pos_tail;
    rd_addr       = front_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    occ_ext       = '0;
    out_occ_nxt   = out_occ_r;
    unique case (state_r)
      deq_pkg::BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_ready = 1'b1;
          if (cmd.is_ins) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            if (full) begin
              out_st_nxt = deq_pkg::ST_FULL;
            end else begin
              out_st_nxt = deq_pkg::ST_DONE;
              wr_en      = 1'b1;
              count_nxt  = count_r + 1'b1;
              if (cmd.at_front) begin
                wr_addr   = front_dec;
                front_nxt = front_dec;
              end else begin
                wr_addr = pos_tail;
              end
            end
          end else if (empty) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_st_nxt    = deq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = deq_pkg::BK_READ;
            if (cmd.at_front) begin
              rd_addr   = front_r;
              front_nxt = front_inc;
            end else begin
              rd_addr = pos_last;
            end
          end
          occ_ext     = {{deq_pkg::OCC_W{1'b0}}, count_nxt};
          out_occ_nxt = occ_ext[deq_pkg::OCC_W-1:0];
        end
      end
      deq_pkg::BK_READ: begin
        // slot was freed when the removal started
        out_valid_nxt = 1'b1;
        out_val_nxt   = rd_data_r;
        out_st_nxt    = deq_pkg::ST_DONE;
        state_nxt     = deq_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_occ_r <= out_occ_nxt;
  end

  // Ring storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_occ_r, out_st_r, out_val_r};

endmodule

[hw/rtl/double_ended_queue.sv]
// Inserts and flagged requests get their result registered once the back end
// accepts them; a removal first passes through BK_READ for the ring read.
// Throughput: one request per cycle for inserts and flagged requests while
// out_tready allows; in a removal's BK_READ state no new request is taken.
// Reset: synchronous active-low rst_n empties the queue and command buffer;
// ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] removed_value, [33:32] status,
                                  // [38:34] occupancy, [39] zero
);

  logic          cmd_valid;
  logic          cmd_ready;
  deq_pkg::cmd_t cmd;

  // Request intake and decode
  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Ring buffer execution
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/double_ended_queue_test.sv]
`timescale 1ns / 1ps

// One expected result of the deque
typedef struct {
  logic [deq_pkg::DATA_W-1:0] removed;
  deq_pkg::status_t           status;
  logic [deq_pkg::OCC_W-1:0]  occ;
} deq_result_t;

// Shadow deque: tracks ring contents and queues the result of every request
class deque_scoreboard;
  int                         ring_depth;
  logic [deq_pkg::DATA_W-1:0] ring [];
  int                         front_pos;
  int                         held;
  deq_result_t                expected_q [$];
  int                         errors;

  function new(int depth);
    ring_depth = depth;
    ring       = new[depth];
    front_pos  = 0;
    held       = 0;
    errors     = 0;
  endfunction

  // Apply one accepted request to the shadow ring
  function void note_request(deq_pkg::mode_t mode, logic [deq_pkg::DATA_W-1:0] value);
    deq_result_t res;
    res.removed = '0;
    res.status  = deq_pkg::ST_DONE;
    case (mode)
      deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_BACK: begin
        if (held >= ring_depth) begin
          res.status = deq_pkg::ST_FULL;
        end else if (mode == deq_pkg::MODE_INS_FRONT) begin
          front_pos = (front_pos + ring_depth - 1) % ring_depth;
          ring[front_pos] = value;
          held++;
        end else begin
          ring[(front_pos + held) % ring_depth] = value;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else if (mode == deq_pkg::MODE_REM_FRONT) begin
          res.removed = ring[front_pos];
          front_pos   = (front_pos + 1) % ring_depth;
          held--;
        end else begin
          res.removed = ring[(front_pos + held - 1) % ring_depth];
          held--;
        end
      end
    endcase
    res.occ = deq_pkg::OCC_W'(held);
    expected_q.push_back(res);
  endfunction

  // Compare one accepted result word with the oldest expectation
  function void check_result(
    logic [deq_pkg::DATA_W+deq_pkg::STATUS_W+deq_pkg::OCC_W:0] word);
    deq_result_t                  want;
    logic [deq_pkg::DATA_W-1:0]   got_val;
    logic [deq_pkg::STATUS_W-1:0] got_st;
    logic [deq_pkg::OCC_W-1:0]    got_occ;
    got_val = word[deq_pkg::DATA_W-1:0];
    got_st  = word[deq_pkg::DATA_W+deq_pkg::STATUS_W-1:deq_pkg::DATA_W];
    got_occ = word[deq_pkg::DATA_W+deq_pkg::STATUS_W+deq_pkg::OCC_W-1:
                   deq_pkg::DATA_W+deq_pkg::STATUS_W];
    if (expected_q.size() == 0) begin
      if (errors < 10)
        $display("ERROR: unexpected result value=%h status=%0d occ=%0d",
                 got_val, got_st, got_occ);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got_val !== want.removed || got_st !== want.status || got_occ !== want.occ) begin
      if (errors < 10)
        $display("ERROR: mismatch exp value=%h st=%0d occ=%0d, got value=%h st=%0d occ=%0d",
                 want.removed, want.status, want.occ, got_val, got_st, got_occ);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module double_ended_queue_test;

  localparam int unsigned DEPTH = deq_pkg::DEF_DEPTH;
  localparam int RESET_CYCLES  = 11;
  localparam int HOLD_CYCLES   = 120;
  localparam int PRESSURE_REQS = 48;
  localparam int PHASE_REQS    = 440;
  localparam int SEGMENT_REQS  = 40;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [1:0]  in_tuser   = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] removed_value, [33:32] status,
                                  // [38:34] occupancy, [39] zero

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int cycle_count   = 0;

  deque_scoreboard sb;

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_test: done, errors");
      $finish;
    end
  end

  // Handshake monitor: requests feed the shadow deque, results get checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(deq_pkg::mode_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random values half the time, the four extremes otherwise
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Insert with probability ins_pct, either end picked at random
  function automatic deq_pkg::mode_t pick_mode(int ins_pct);
    if ($urandom_range(99) < ins_pct)
      return $urandom_range(1) ? deq_pkg::MODE_INS_BACK : deq_pkg::MODE_INS_FRONT;
    return $urandom_range(1) ? deq_pkg::MODE_REM_BACK : deq_pkg::MODE_REM_FRONT;
  endfunction

  // Offer one request; returns at the rising edge that accepted it
  task automatic push_request(input deq_pkg::mode_t mode, input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // Random traffic in segments that lean toward filling, draining or neither
  task automatic run_random(input int idle_pct, input int stall, input int count);
    int ins_pct;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    ins_pct       = 50;
    for (int i = 0; i < count; i++) begin
      if (i % SEGMENT_REQS == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 80;
          1:       ins_pct = 50;
          default: ins_pct = 20;
        endcase
      end
      push_request(pick_mode(ins_pct), pick_value());
    end
  endtask

  initial begin
    sb = new(DEPTH);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Removals from an empty queue, both ends
    push_request(deq_pkg::MODE_REM_FRONT, 32'h1234_5678);
    push_request(deq_pkg::MODE_REM_BACK,  32'hedcb_a987);
    // Sole element taken from the back, then from the front
    push_request(deq_pkg::MODE_INS_FRONT, 32'h7fff_ffff);
    push_request(deq_pkg::MODE_REM_BACK,  32'h0);
    push_request(deq_pkg::MODE_INS_BACK,  32'h8000_0000);
    push_request(deq_pkg::MODE_REM_FRONT, 32'hffff_ffff);
    // Fill to capacity from both ends
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       push_request(deq_pkg::MODE_INS_FRONT, 32'h5555_5555);
        1:       push_request(deq_pkg::MODE_INS_BACK,  32'haaaa_aaaa);
        2:       push_request(deq_pkg::MODE_INS_FRONT, 32'hffff_ffff);
        default: push_request(deq_pkg::MODE_INS_BACK,  $urandom);
      endcase
    end
    // Inserts into a full queue are dropped
    push_request(deq_pkg::MODE_INS_FRONT, 32'h0000_0001);
    push_request(deq_pkg::MODE_INS_BACK,  32'h8000_0000);

    // Random phases; long receiver hold-off after the first
    run_random(0, 0, PHASE_REQS);
    @(negedge clk);
    in_tvalid <= 1'b0;
    hold_req = 1'b1;
    send_idle_pct = 0;
    for (int i = 0; i < PRESSURE_REQS; i++)
      push_request(pick_mode(85), pick_value());
    run_random(69, 0,  PHASE_REQS);
    run_random(0,  69, PHASE_REQS);
    run_random(28, 28, PHASE_REQS);

    // Drain
    stall_pct = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("double_ended_queue_test: done, clean");
    end else begin
      $display("double_ended_queue_test: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/deq_pkg.sv
hw/rtl/deq_front.sv
hw/rtl/deq_back.sv
hw/rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
